FILE: rtl/core/bfa_pkg.sv
// shared types, constants and mask helpers for the bitmap frame allocator
// no dependencies
`default_nettype none
package bfa_pkg;

  localparam int unsigned MAX_FRAMES  = 1048576;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAP_WORDS   = MAX_FRAMES / WORD_BITS;
  localparam int unsigned FW          = 21;
  localparam int unsigned AW          = $clog2(MAP_WORDS);
  localparam int unsigned SHIFT       = $clog2(FRAME_BYTES);
  localparam int unsigned BW          = $clog2(WORD_BITS);

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_BLOCK = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  localparam logic [1:0] REG_TOTAL = 2'd0;
  localparam logic [1:0] REG_FIRST = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;

  typedef logic [FW-1:0] frame_t;
  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic          rd;
    logic          wr;
    logic [AW-1:0] addr;
    word_t         wdata;
  } map_req_t;

  // bits of the word at base that fall into frames [lo, hi)
  function automatic word_t range_mask(input frame_t base, input frame_t lo, input frame_t hi);
    logic [FW-1:0] lo_d;
    logic [FW-1:0] hi_d;
    logic [BW:0]   lo_k;
    logic [BW:0]   hi_k;
    word_t         ones;
    ones = '1;
    lo_d = (lo > base) ? lo - base : '0;
    hi_d = (hi > base) ? hi - base : '0;
    lo_k = (lo_d >= FW'(WORD_BITS)) ? (BW+1)'(WORD_BITS) : lo_d[BW:0];
    hi_k = (hi_d >= FW'(WORD_BITS)) ? (BW+1)'(WORD_BITS) : hi_d[BW:0];
    return (ones << lo_k) & ~(ones << hi_k);
  endfunction

  function automatic logic [BW-1:0] lowest_set(input word_t w);
    logic [BW-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = BW'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bfa_map.sv
// used-frame bitmap storage, one word read or written per cycle
// depends on bfa_pkg
`default_nettype none
module bfa_map
  import bfa_pkg::*;
(
  input  wire logic     clk,
  input  wire map_req_t req,
  output word_t         rdata_r
);

  word_t mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.addr] <= req.wdata;
    if (req.rd) rdata_r <= mem[req.addr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/bitmap_frame_allocator.sv
// bitmap frame allocator top level: command sequencer over the bitmap word unit
// depends on bfa_pkg, bfa_map
`default_nettype none
// One command is taken at a time and answered with exactly one result. The
// bitmap is one single-port memory of 32768 words, visited one word at a time
// by the sequencer. After reset, and again for every init command, a sweep
// writes all 32768 words (one per cycle) while in_tready is low; init writes
// the reserved range in the same sweep. Allocate-one reads words from the
// hint up to the frame total and then from frame 0. Allocate-block skips fully
// used words, and fully free words while the run stays short of the length,
// and walks other words one bit per cycle, then writes the run back with a
// read and a write per word. Configuration writes are accepted in any cycle
// outside reset.
module bitmap_frame_allocator
  import bfa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [55:0] in_tdata,  // block_length[20:0], free_address[52:21]
  input  wire logic [1:0]  in_tuser,  // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata, // frame_address[31:0], free_count[52:32]
  output logic             out_tuser, // ok
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'h0001,
    S_CLR   = 13'h0002,
    S_A1_RD = 13'h0004,
    S_A1_EV = 13'h0008,
    S_A1_PE = 13'h0010,
    S_AB_RD = 13'h0020,
    S_AB_EV = 13'h0040,
    S_AB_BT = 13'h0080,
    S_MK_RD = 13'h0100,
    S_MK_EV = 13'h0200,
    S_FR_RD = 13'h0400,
    S_FR_EV = 13'h0800,
    S_FIN   = 13'h1000
  } state_t;

  state_t state_r, state_nxt;
  frame_t total_r, first_r, end_r;
  frame_t free_r, free_nxt, hint_r, hint_nxt;
  frame_t base_r, base_nxt, lo_r, lo_nxt, run_r, run_nxt, start_r, start_nxt, len_r, len_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;
  logic [BW-1:0] bit_r, bit_nxt;
  logic pass_r, pass_nxt, init_r, init_nxt;
  logic [19:0] ffrm_r, ffrm_nxt;
  logic ok_r, ok_nxt;
  logic [31:0] res_r, res_nxt;
  word_t word_r, word_nxt;
  logic ovalid_r, ovalid_nxt;
  logic ook_r;
  logic [31:0] oaddr_r;
  frame_t ofree_r;
  map_req_t req;
  word_t rdata;

  frame_t t, stop, cnt, blk_end, fcur;
  word_t  m;
  logic [FW:0] base32;

  bfa_map u_map (.clk(clk), .req(req), .rdata_r(rdata));

  assign t       = (total_r > frame_t'(MAX_FRAMES)) ? frame_t'(MAX_FRAMES) : total_r;
  assign stop    = (end_r < t) ? end_r : t;
  assign cnt     = (stop > first_r) ? stop - first_r : '0;
  assign blk_end = start_r + len_r;
  assign base32  = {1'b0, base_r} + (FW+1)'(WORD_BITS);
  assign fcur    = base_r + FW'(bit_r);

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tuser  = ook_r;
  assign out_tdata  = {3'b0, ofree_r, oaddr_r};

  function automatic frame_t hint_add(input frame_t h, input frame_t n, input frame_t tt);
    return (h >= tt || n >= tt - h) ? tt : h + n;
  endfunction

  always_comb begin
    state_nxt = state_r;
    free_nxt = free_r;  hint_nxt = hint_r;  base_nxt = base_r;  lo_nxt = lo_r;
    run_nxt = run_r;    start_nxt = start_r; len_nxt = len_r;   sweep_nxt = sweep_r;
    bit_nxt = bit_r;    pass_nxt = pass_r;   init_nxt = init_r; ffrm_nxt = ffrm_r;
    ok_nxt = ok_r;      res_nxt = res_r;     word_nxt = word_r; ovalid_nxt = ovalid_r;
    req = '0;
    m = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ok_nxt  = 1'b1;
          res_nxt = '0;
          len_nxt = in_tdata[20:0];
          unique case (in_tuser)
            CMD_INIT: begin
              sweep_nxt = '0;
              init_nxt  = 1'b1;
              state_nxt = S_CLR;
            end
            CMD_ALLOC: begin
              pass_nxt = 1'b0;
              lo_nxt   = hint_r;
              base_nxt = {hint_r[FW-1:BW], BW'(0)};
              if (free_r == '0) begin
                ok_nxt = 1'b0;
                state_nxt = S_FIN;
              end else if (hint_r >= t) begin
                state_nxt = S_A1_PE;
              end else begin
                state_nxt = S_A1_RD;
              end
            end
            CMD_BLOCK: begin
              base_nxt = '0;
              run_nxt  = '0;
              if (in_tdata[20:0] == '0) begin
                ok_nxt = 1'b0;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_AB_RD;
              end
            end
            default: begin
              ffrm_nxt = in_tdata[52:21+SHIFT];
              if ({1'b0, in_tdata[52:21+SHIFT]} >= t) begin
                ok_nxt = 1'b0;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FR_RD;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        req.wr    = 1'b1;
        req.addr  = sweep_r;
        req.wdata = init_r ? range_mask(FW'({sweep_r, BW'(0)}), first_r, stop) : '0;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == '1) begin
          if (init_r) begin
            free_nxt  = t - cnt;
            hint_nxt  = (end_r > first_r) ? hint_add('0, end_r - first_r, t) : '0;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_A1_RD: begin
        req.rd    = 1'b1;
        req.addr  = base_r[FW-2:BW];
        state_nxt = S_A1_EV;
      end
      S_A1_EV: begin
        m = range_mask(base_r, lo_r, t) & ~rdata;
        if (m != '0) begin
          req.wr    = 1'b1;
          req.addr  = base_r[FW-2:BW];
          req.wdata = rdata | (word_t'(1) << lowest_set(m));
          res_nxt   = {base_r[19:BW], lowest_set(m), SHIFT'(0)};
          if (free_r != '0) free_nxt = free_r - 1'b1;
          hint_nxt  = hint_add(hint_r, FW'(1), t);
          state_nxt = S_FIN;
        end else if (base32 >= {1'b0, t}) begin
          state_nxt = S_A1_PE;
        end else begin
          base_nxt  = base32[FW-1:0];
          state_nxt = S_A1_RD;
        end
      end
      S_A1_PE: begin
        hint_nxt = '0;
        if (!pass_r && t != '0) begin
          pass_nxt  = 1'b1;
          lo_nxt    = '0;
          base_nxt  = '0;
          state_nxt = S_A1_RD;
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_AB_RD: begin
        if (base_r >= t) begin
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end else begin
          req.rd    = 1'b1;
          req.addr  = base_r[FW-2:BW];
          state_nxt = S_AB_EV;
        end
      end
      S_AB_EV: begin
        word_nxt = rdata;
        bit_nxt  = '0;
        if (base32 <= {1'b0, t} && rdata == '1) begin
          run_nxt   = '0;
          base_nxt  = base32[FW-1:0];
          state_nxt = S_AB_RD;
        end else if (base32 <= {1'b0, t} && rdata == '0 &&
                     ({1'b0, run_r} + (FW+1)'(WORD_BITS)) < {1'b0, len_r}) begin
          if (run_r == '0) start_nxt = base_r;
          run_nxt   = run_r + FW'(WORD_BITS);
          base_nxt  = base32[FW-1:0];
          state_nxt = S_AB_RD;
        end else begin
          state_nxt = S_AB_BT;
        end
      end
      S_AB_BT: begin
        bit_nxt = bit_r + 1'b1;
        if (fcur >= t) begin
          ok_nxt    = 1'b0;
          state_nxt = S_FIN;
        end else if (word_r[bit_r]) begin
          run_nxt = '0;
          if (bit_r == '1) begin
            base_nxt  = base32[FW-1:0];
            state_nxt = S_AB_RD;
          end
        end else begin
          if (run_r == '0) start_nxt = fcur;
          run_nxt = run_r + 1'b1;
          if (run_r + 1'b1 == len_r) begin
            if (run_r == '0) begin
              base_nxt = {fcur[FW-1:BW], BW'(0)};
            end else begin
              base_nxt = {start_r[FW-1:BW], BW'(0)};
            end
            state_nxt = S_MK_RD;
          end else if (bit_r == '1) begin
            base_nxt  = base32[FW-1:0];
            state_nxt = S_AB_RD;
          end
        end
      end
      S_MK_RD: begin
        req.rd    = 1'b1;
        req.addr  = base_r[FW-2:BW];
        state_nxt = S_MK_EV;
      end
      S_MK_EV: begin
        req.wr    = 1'b1;
        req.addr  = base_r[FW-2:BW];
        req.wdata = rdata | range_mask(base_r, start_r, blk_end);
        if (base32 >= {1'b0, blk_end}) begin
          res_nxt   = {start_r[19:0], SHIFT'(0)};
          free_nxt  = (free_r > len_r) ? free_r - len_r : '0;
          hint_nxt  = hint_add(hint_r, len_r, t);
          state_nxt = S_FIN;
        end else begin
          base_nxt  = base32[FW-1:0];
          state_nxt = S_MK_RD;
        end
      end
      S_FR_RD: begin
        req.rd    = 1'b1;
        req.addr  = ffrm_r[19:BW];
        state_nxt = S_FR_EV;
      end
      S_FR_EV: begin
        if (rdata[ffrm_r[BW-1:0]]) begin
          req.wr    = 1'b1;
          req.addr  = ffrm_r[19:BW];
          req.wdata = rdata & ~(word_t'(1) << ffrm_r[BW-1:0]);
          free_nxt  = free_r + 1'b1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      sweep_r  <= '0;
      init_r   <= 1'b0;
      free_r   <= '0;
      hint_r   <= '0;
      ovalid_r <= 1'b0;
      total_r  <= frame_t'(MAX_FRAMES);
      first_r  <= '0;
      end_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      sweep_r  <= sweep_nxt;
      init_r   <= init_nxt;
      free_r   <= free_nxt;
      hint_r   <= hint_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_TOTAL: total_r <= cfg_data;
          REG_FIRST: first_r <= cfg_data;
          REG_END:   end_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r  <= base_nxt;
    lo_r    <= lo_nxt;
    run_r   <= run_nxt;
    start_r <= start_nxt;
    len_r   <= len_nxt;
    bit_r   <= bit_nxt;
    pass_r  <= pass_nxt;
    ffrm_r  <= ffrm_nxt;
    ok_r    <= ok_nxt;
    res_r   <= res_nxt;
    word_r  <= word_nxt;
    if (state_r == S_FIN && (!ovalid_r || out_tready)) begin
      ook_r   <= ok_r;
      oaddr_r <= res_r;
      ofree_r <= free_r;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bfa_checker.sv
// port-level checks for the bitmap frame allocator, bound to the top level
// depends on bitmap_frame_allocator ports only
`default_nettype none
module bfa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command accepted back to back");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[31:0] == 32'd0)
    else $error("failed command returned an address");

  a_addr_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[11:0] == 12'd0)
    else $error("unaligned frame address");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
